// ----- rtl/timing_wheel_packet_shaper_macros.svh -----
// Assertion macros for the timing wheel shaper.
// Each check is clocked on i_clk and disabled while i_rst_n is low.
`ifndef TIMING_WHEEL_PACKET_SHAPER_MACROS_SVH
`define TIMING_WHEEL_PACKET_SHAPER_MACROS_SVH
`ifndef SYNTHESIS
`define TWPS_ASSERT_IMP(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`define TWPS_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define TWPS_ASSERT_IMP(lbl, cond, conseq, msg)
`define TWPS_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif
`endif

// ----- rtl/twps_pkg.sv -----
package twps_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 16;
    localparam int KIND_W = 3;
    localparam int GRAN_W = 6;

    localparam logic [KIND_W-1:0] KIND_BYPASS  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DRAINED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAST    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FUTURE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd4;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    localparam logic REG_GRAN    = 1'b0;
    localparam logic REG_HORIZON = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] departure_time;
        logic [ID_W-1:0]   packet_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   out_packet_id;
        logic [KIND_W-1:0] result_kind;
        logic              last;
    } t_out_item;

endpackage

// ----- rtl/twps_slot_mod.sv -----
module twps_slot_mod import twps_pkg::*; #(
    parameter int SLOTS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [TIME_W:0]          i_q,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_slot
);

    localparam int SW = $clog2(SLOTS);

    generate
        if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
            // A power-of-two wheel takes the low bits of the slot number.
            logic          r_done;
            logic [SW-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_slot <= i_q[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_fold
            // The slot number is folded into a short sum of 12-bit chunks times their
            // weights modulo SLOTS, and the sum is reduced by a reciprocal multiplication.
            // Three pipeline stages follow the input register.
            localparam int FW = 27;
            localparam int PW = 55;
            localparam int SH = FW + SW;
            localparam longint unsigned M_C =
                ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
            localparam logic [FW-1:0] W1  = FW'((64'd1 << 12) % 64'(SLOTS));
            localparam logic [FW-1:0] W2  = FW'((64'd1 << 24) % 64'(SLOTS));
            localparam logic [FW-1:0] W3  = FW'((64'd1 << 36) % 64'(SLOTS));
            localparam logic [FW-1:0] W4  = FW'((64'd1 << 48) % 64'(SLOTS));
            localparam logic [PW-1:0] M_V = PW'(M_C);
            localparam logic [FW-1:0] D_V = FW'(SLOTS);

            logic [TIME_W:0] r_q;
            logic [FW-1:0]   fold_sum;
            logic [FW-1:0]   r_sum;
            logic [PW-1:0]   prod;
            logic [FW-1:0]   r_quo;
            logic [FW-1:0]   rem_full;
            logic [SW-1:0]   r_rem;
            logic            r_v1, r_v2, r_v3, r_done;

            assign fold_sum = FW'(r_q[11:0]) + FW'(r_q[23:12]) * W1 +
                              FW'(r_q[35:24]) * W2 + FW'(r_q[47:36]) * W3 +
                              FW'(r_q[48]) * W4;
            assign prod     = PW'(r_sum) * M_V;
            assign rem_full = r_sum - r_quo * D_V;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_v3   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_start;
                    r_v2   <= r_v1;
                    r_v3   <= r_v2;
                    r_done <= r_v3;
                end
                if (i_start) begin
                    r_q <= i_q;
                end
                if (r_v1) begin
                    r_sum <= fold_sum;
                end
                if (r_v2) begin
                    r_quo <= FW'(prod >> SH);
                end
                if (r_v3) begin
                    r_rem <= rem_full[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_rem;
        end
    endgenerate

endmodule

// ----- rtl/twps_slot_mem.sv -----
module twps_slot_mem #(
    parameter int SW = 8,
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic [SW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [2**SW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/twps_link_mem.sv -----
module twps_link_mem import twps_pkg::*; #(
    parameter int EW = 8
) (
    input  logic            i_clk,
    input  logic [EW-1:0]   i_raddr,
    output logic [EW-1:0]   o_next,
    output logic [ID_W-1:0] o_pkt,
    input  logic            i_next_we,
    input  logic [EW-1:0]   i_next_waddr,
    input  logic [EW-1:0]   i_next_wdata,
    input  logic            i_pkt_we,
    input  logic [EW-1:0]   i_pkt_waddr,
    input  logic [ID_W-1:0] i_pkt_wdata
);

    // Links of the slot lists and of the free list share one array.
    logic [EW-1:0]   r_next_mem [2**EW];
    logic [ID_W-1:0] r_pkt_mem  [2**EW];
    logic [EW-1:0]   r_next;
    logic [ID_W-1:0] r_pkt;

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            r_next_mem[i_next_waddr] <= i_next_wdata;
        end
        if (i_pkt_we) begin
            r_pkt_mem[i_pkt_waddr] <= i_pkt_wdata;
        end
        r_next <= r_next_mem[i_raddr];
        r_pkt  <= r_pkt_mem[i_raddr];
    end

    assign o_next = r_next;
    assign o_pkt  = r_pkt;

endmodule

// ----- rtl/timing_wheel_packet_shaper.sv -----
// Timing wheel packet shaper, one item in flight at a time.
// Enqueue: CALC, MOD (longer when SLOTS is not a power of two), SRD and ENQ, then EMIT when the
// packet is dropped; bypass and range rejects go from CALC to EMIT. A stalled result adds its wait.
// Tick: CALC, MOD, SRD, DHEAD, then DRN releases one packet per cycle while the output can take it.
// Reset is synchronous and active low; afterwards a clearing pass over every slot and store
// entry sets up the slot counts and the free list before the first item is accepted.
`include "timing_wheel_packet_shaper_macros.svh"
module timing_wheel_packet_shaper import twps_pkg::*; #(
    parameter int SLOTS        = 256,
    parameter int CAPACITY     = 256,
    parameter int MAX_PER_SLOT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int SW     = $clog2(SLOTS);
    localparam int EW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(MAX_PER_SLOT + 1);
    localparam int FCW    = $clog2(CAPACITY + 1);
    localparam int INIT_D = (SLOTS > CAPACITY) ? SLOTS : CAPACITY;
    localparam int IW     = $clog2(INIT_D);
    localparam int SDW    = 2 * EW + CW;

    // Sequencer states.
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_SRD   = 4'd4;
    localparam logic [3:0] S_ENQ   = 4'd5;
    localparam logic [3:0] S_DHEAD = 4'd6;
    localparam logic [3:0] S_DRN   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // Configuration registers. Only bit 3 of the address selects a register.
    logic [GRAN_W-1:0] r_gran;
    logic [TIME_W-1:0] r_horizon;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran    <= GRAN_W'(10);
            r_horizon <= TIME_W'(1048576);
        end else if (cfg_wr) begin
            if (paddr[3] == REG_GRAN) begin
                r_gran <= pwdata[GRAN_W-1:0];
            end else begin
                r_horizon <= pwdata[TIME_W-1:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_HORIZON) ? {16'd0, r_horizon} : {58'd0, r_gran};

    // Control state.
    logic [3:0]     r_state, n_state;
    logic [IW-1:0]  r_init;
    t_in_item       r_item;
    logic [KIND_W-1:0] r_kind;
    logic [EW-1:0]  r_free_head;
    logic [FCW-1:0] r_free_count;
    logic [EW-1:0]  r_cur;
    logic [CW-1:0]  r_n;
    logic           r_out_valid;
    t_out_item      r_out;

    logic out_take, can_emit, in_accept;
    assign out_take  = r_out_valid && !i_out_stall;
    assign can_emit  = !r_out_valid || out_take;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Range checks and the rounded slot number of the item in hand.
    logic [TIME_W:0]   past_sum, fut_sum;
    logic              too_past, too_future, is_bypass;
    logic [TIME_W-1:0] t_sel, t_low;
    logic              round_up;
    logic [TIME_W:0]   q;

    assign past_sum   = {1'b0, r_item.departure_time} + {1'b0, r_horizon};
    assign fut_sum    = {1'b0, r_item.now_time} + {1'b0, r_horizon};
    assign too_past   = past_sum < {1'b0, r_item.now_time};
    assign too_future = {1'b0, r_item.departure_time} > fut_sum;
    assign is_bypass  = (r_item.departure_time == '0);

    // A tick uses now without rounding; an enqueue raises a past time to now.
    assign t_sel = (r_item.action == ACT_TICK) ? r_item.now_time :
                   ((r_item.departure_time < r_item.now_time) ? r_item.now_time
                                                              : r_item.departure_time);
    assign t_low    = t_sel & ~({TIME_W{1'b1}} << r_gran);
    assign round_up = (r_item.action == ACT_ENQUEUE) && (t_low != '0);
    assign q        = {1'b0, t_sel >> r_gran} + (TIME_W+1)'(round_up);

    logic          mod_start, mod_done;
    logic [SW-1:0] slot;

    assign mod_start = (r_state == S_CALC) &&
                       ((r_item.action == ACT_TICK) || !(is_bypass || too_past || too_future));

    twps_slot_mod #(.SLOTS(SLOTS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_q     (q),
        .o_done  (mod_done),
        .o_slot  (slot)
    );

    // Slot memory: head, tail and count of each slot's list.
    logic [SDW-1:0] s_rdata, s_wdata;
    logic           s_we;
    logic [SW-1:0]  s_waddr;
    logic [EW-1:0]  s_head, s_tail;
    logic [CW-1:0]  s_count;

    assign s_head  = s_rdata[SDW-1 -: EW];
    assign s_tail  = s_rdata[CW +: EW];
    assign s_count = s_rdata[CW-1:0];

    twps_slot_mem #(.SW(SW), .DW(SDW)) u_slot_mem (
        .i_clk   (i_clk),
        .i_raddr (slot),
        .o_rdata (s_rdata),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata)
    );

    // Link memory: next pointers and stored handles.
    logic [EW-1:0]   l_raddr, l_next, l_next_waddr, l_next_wdata, l_pkt_waddr;
    logic [ID_W-1:0] l_pkt;
    logic            l_next_we, l_pkt_we;

    twps_link_mem #(.EW(EW)) u_link_mem (
        .i_clk        (i_clk),
        .i_raddr      (l_raddr),
        .o_next       (l_next),
        .o_pkt        (l_pkt),
        .i_next_we    (l_next_we),
        .i_next_waddr (l_next_waddr),
        .i_next_wdata (l_next_wdata),
        .i_pkt_we     (l_pkt_we),
        .i_pkt_waddr  (l_pkt_waddr),
        .i_pkt_wdata  (r_item.packet_id)
    );

    assign l_pkt_waddr = r_free_head;

    logic enq_ok, drain_emit, init_last;
    assign enq_ok     = (s_count < CW'(MAX_PER_SLOT)) && (r_free_count != '0);
    assign drain_emit = (r_state == S_DRN) && can_emit;
    assign init_last  = (r_init == IW'(INIT_D - 1));

    // Memory port steering. The clearing pass chains every store entry into
    // the free list and empties every slot.
    always_comb begin
        s_we         = 1'b0;
        s_waddr      = slot;
        s_wdata      = s_rdata;
        l_raddr      = r_free_head;
        l_next_we    = 1'b0;
        l_next_waddr = r_cur;
        l_next_wdata = r_free_head;
        l_pkt_we     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                s_we         = ({1'b0, r_init} < (IW+1)'(SLOTS));
                s_waddr      = r_init[SW-1:0];
                s_wdata      = '0;
                l_next_we    = ({1'b0, r_init} < (IW+1)'(CAPACITY));
                l_next_waddr = r_init[EW-1:0];
                l_next_wdata = EW'({1'b0, r_init} + 1'b1);
            end
            S_ENQ: begin
                if (enq_ok) begin
                    s_we         = 1'b1;
                    s_wdata      = {(s_count == '0) ? r_free_head : s_head, r_free_head,
                                    CW'(s_count + 1'b1)};
                    l_pkt_we     = 1'b1;
                    l_next_we    = (s_count != '0);
                    l_next_waddr = s_tail;
                    l_next_wdata = r_free_head;
                end
            end
            S_DHEAD: begin
                l_raddr = s_head;
                if (s_count != '0) begin
                    s_we    = 1'b1;
                    s_wdata = {s_head, s_tail, {CW{1'b0}}};
                end
            end
            S_DRN: begin
                // A released entry goes back on top of the free list.
                l_raddr = drain_emit ? l_next : r_cur;
                l_next_we = drain_emit;
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  if (init_last) n_state = S_IDLE;
            S_IDLE:  if (in_accept) n_state = S_CALC;
            S_CALC:  n_state = mod_start ? S_MOD : S_EMIT;
            S_MOD:   if (mod_done) n_state = S_SRD;
            S_SRD:   n_state = (r_item.action == ACT_TICK) ? S_DHEAD : S_ENQ;
            S_ENQ:   n_state = enq_ok ? S_IDLE : S_EMIT;
            S_DHEAD: n_state = (s_count == '0) ? S_IDLE : S_DRN;
            S_DRN:   if (drain_emit && (r_n == CW'(1))) n_state = S_IDLE;
            S_EMIT:  if (can_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init       <= '0;
            r_free_head  <= '0;
            r_free_count <= FCW'(CAPACITY);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_init <= IW'({1'b0, r_init} + 1'b1);
            end
            if ((r_state == S_ENQ) && enq_ok) begin
                r_free_head  <= l_next;
                r_free_count <= r_free_count - 1'b1;
            end else if (drain_emit) begin
                r_free_head  <= r_cur;
                r_free_count <= r_free_count + 1'b1;
            end
            if (((r_state == S_EMIT) && can_emit) || drain_emit) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        if (r_state == S_CALC) begin
            priority if (is_bypass) begin
                r_kind <= KIND_BYPASS;
            end else if (too_past) begin
                r_kind <= KIND_PAST;
            end else begin
                r_kind <= KIND_FUTURE;
            end
        end else if (r_state == S_ENQ) begin
            r_kind <= KIND_DROPPED;
        end
        if (r_state == S_DHEAD) begin
            r_cur <= s_head;
            r_n   <= s_count;
        end else if (drain_emit) begin
            r_cur <= l_next;
            r_n   <= r_n - 1'b1;
        end
        if ((r_state == S_EMIT) && can_emit) begin
            r_out.out_packet_id <= r_item.packet_id;
            r_out.result_kind   <= r_kind;
            r_out.last          <= 1'b1;
        end else if (drain_emit) begin
            r_out.out_packet_id <= l_pkt;
            r_out.result_kind   <= KIND_DRAINED;
            r_out.last          <= (r_n == CW'(1));
        end
    end

    // The free count never runs past the store size.
    `TWPS_ASSERT_IMP(a_free_bound, 1'b1, r_free_count <= FCW'(CAPACITY), "free count overflow")
    // A successful enqueue takes exactly one store entry.
    `TWPS_ASSERT_NEXT(a_enq_alloc, (r_state == S_ENQ) && enq_ok,
        r_free_count == $past(r_free_count) - 1'b1, "enqueue did not take one entry")
    // Releasing the last packet of a slot ends the drain.
    `TWPS_ASSERT_NEXT(a_drain_end, drain_emit && (r_n == CW'(1)), r_state == S_IDLE,
        "drain did not end on last packet")

endmodule
